/* rtl/oudmm_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and helpers for the odd-unit distance mask minimum block.
// Depends on nothing; the lane, merge and top-level files in rtl/ refer to it by scoped names.
package oudmm_pkg;

   // Group order and support size follow from the fixed request fields.
   localparam int ORDER   = 128;
   localparam int POINTS  = 4;
   localparam int POINT_W = $clog2(ORDER);
   localparam int HALF    = ORDER / 2;
   localparam int MASK_W  = HALF - 1;
   localparam int DIST_W  = $clog2(HALF);
   localparam int PAIRS   = POINTS * (POINTS - 1) / 2;

   // Pair enumeration: (i, j) with i < j, in row order.
   localparam int PAIR_A [PAIRS] = '{0, 0, 0, 1, 1, 2};
   localparam int PAIR_B [PAIRS] = '{1, 2, 3, 2, 3, 3};

   typedef logic [POINT_W-1:0] point_type;
   typedef logic [MASK_W-1:0]  mask_type;
   typedef point_type [POINTS-1:0] points_type;

   typedef struct packed {
      point_type point_3;
      point_type point_2;
      point_type point_1;
      point_type point_0;
   } req_type;

   typedef struct packed {
      mask_type min_mask;
      logic     degenerate;
   } rsp_type;

   // Travels alongside the lane results: one beat per sweep step.
   typedef struct packed {
      logic valid;
      logic first;
      logic last;
   } ctl_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SWEEP,
      ST_DRAIN,
      ST_HOLD
   } state_type;

   function automatic mask_type mask_min(input mask_type a, input mask_type b);
      return (b < a) ? b : a;
   endfunction

endpackage

/* rtl/oudmm_stream_if.sv */
`timescale 1ns / 1ps
// Valid/ready stream interface used for the request and response channels.
// Payload type is set per instance; the interface itself does not refer to oudmm_pkg.
interface oudmm_stream_if #(
   parameter type payload_type = logic
) ();
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

/* rtl/oudmm_lane.sv */
`timescale 1ns / 1ps
// One multiplier lane: scales the support by an odd unit and builds its distance mask.
// Depends on oudmm_pkg. Two register stages: products, then mask.
module oudmm_lane (
   input  logic                  clock,
   input  oudmm_pkg::points_type pts,
   input  oudmm_pkg::point_type  unit,
   output oudmm_pkg::mask_type   mask
);

   logic [2*oudmm_pkg::POINT_W-1:0] prod [oudmm_pkg::POINTS];
   oudmm_pkg::points_type img_in;
   oudmm_pkg::points_type img_ff;
   oudmm_pkg::point_type  diff [oudmm_pkg::PAIRS];
   oudmm_pkg::point_type  fold [oudmm_pkg::PAIRS];
   oudmm_pkg::mask_type   mask_in;
   oudmm_pkg::mask_type   mask_ff;

   // Stage 1: products modulo the order are the low bits.
   always_comb begin
      for (int i = 0; i < oudmm_pkg::POINTS; i++) begin
         prod[i]   = pts[i] * unit;
         img_in[i] = prod[i][oudmm_pkg::POINT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      img_ff <= img_in;
   end

   // Stage 2: folded distances, reject zero, half order or repeats.
   always_comb begin
      logic bad;
      mask_in = '0;
      bad     = 1'b0;
      for (int k = 0; k < oudmm_pkg::PAIRS; k++) begin
         diff[k] = img_ff[oudmm_pkg::PAIR_B[k]] - img_ff[oudmm_pkg::PAIR_A[k]];
         fold[k] = diff[k][oudmm_pkg::POINT_W-1]
                   ? oudmm_pkg::point_type'(oudmm_pkg::point_type'(0) - diff[k])
                   : diff[k];
         if (fold[k] == '0 || fold[k] == oudmm_pkg::point_type'(oudmm_pkg::HALF)) begin
            bad = 1'b1;
         end
         mask_in = mask_in | (oudmm_pkg::mask_type'(1)
                   << (fold[k] - oudmm_pkg::point_type'(1)));
      end
      for (int a = 0; a < oudmm_pkg::PAIRS; a++) begin
         for (int b = a + 1; b < oudmm_pkg::PAIRS; b++) begin
            if (fold[a] == fold[b]) begin
               bad = 1'b1;
            end
         end
      end
      if (bad) begin
         mask_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      mask_ff <= mask_in;
   end

   assign mask = mask_ff;

endmodule

/* rtl/oudmm_merge.sv */
`timescale 1ns / 1ps
// Merging stage: registered minimum tree across the lanes, then a running minimum.
// Depends on oudmm_pkg. Stages: log2(LANES) tree levels plus one accumulate stage.
module oudmm_merge #(
   parameter int LANES = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  oudmm_pkg::ctl_type   ctl,
   input  oudmm_pkg::mask_type  lane_mask [LANES],
   output logic                 done,
   output oudmm_pkg::mask_type  result
);

   localparam int LEVELS = $clog2(LANES);

   oudmm_pkg::mask_type tree_ff [LEVELS][LANES];
   oudmm_pkg::ctl_type  ctl_ff  [LEVELS];
   oudmm_pkg::mask_type acc_in;
   oudmm_pkg::mask_type acc_ff;
   logic                done_in;
   logic                done_ff;

   for (genvar lv = 0; lv < LEVELS; lv++) begin : g_level
      for (genvar n = 0; n < LANES; n++) begin : g_node
         if (n < (LANES >> (lv + 1))) begin : g_used
            if (lv == 0) begin : g_leaf
               always_ff @(posedge clock) begin
                  tree_ff[lv][n] <= oudmm_pkg::mask_min(lane_mask[2*n], lane_mask[2*n+1]);
               end
            end else begin : g_inner
               always_ff @(posedge clock) begin
                  tree_ff[lv][n] <= oudmm_pkg::mask_min(tree_ff[lv-1][2*n],
                                                        tree_ff[lv-1][2*n+1]);
               end
            end
         end else begin : g_spare
            assign tree_ff[lv][n] = '0;
         end
      end

      if (lv == 0) begin : g_ctl_leaf
         always_ff @(posedge clock) begin
            if (reset) begin
               ctl_ff[lv] <= '0;
            end else begin
               ctl_ff[lv] <= ctl;
            end
         end
      end else begin : g_ctl_inner
         always_ff @(posedge clock) begin
            if (reset) begin
               ctl_ff[lv] <= '0;
            end else begin
               ctl_ff[lv] <= ctl_ff[lv-1];
            end
         end
      end
   end

   // Restart on the first beat, fold in later beats, flag the last.
   always_comb begin
      acc_in  = acc_ff;
      done_in = 1'b0;
      if (ctl_ff[LEVELS-1].valid) begin
         acc_in  = ctl_ff[LEVELS-1].first ? tree_ff[LEVELS-1][0]
                   : oudmm_pkg::mask_min(acc_ff, tree_ff[LEVELS-1][0]);
         done_in = ctl_ff[LEVELS-1].last;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff <= 1'b0;
      end else begin
         done_ff <= done_in;
      end
   end

   assign done   = done_ff;
   assign result = acc_ff;

endmodule

/* rtl/odd_unit_distance_mask_min.sv */
`timescale 1ns / 1ps
// Top level of the odd-unit distance mask minimum block: control, lanes and merge.
// Depends on oudmm_pkg, oudmm_stream_if, oudmm_lane and oudmm_merge.
//
//   channel | dir | payload                               | handshake
//   --------+-----+---------------------------------------+------------------
//   req_ch  | in  | point_0..point_3, 7 bits each         | valid/ready
//   rsp_ch  | out | min_mask 63 bits, degenerate 1 bit    | valid/ready
//
// One request passes through the sweep of 64/LANES steps over the odd units, the
// two lane stages, the merge tree, the accumulator, the hand-off state and a
// return to idle.
// Reset is synchronous and clears the state machine and all valid flags.
// The result sits in its own register, so a new request is taken while a
// stalled response waits; the hand-off only waits when that register is still full.
module odd_unit_distance_mask_min #(
   parameter int LANES = 8   // power of two, 2 to 32
) (
   input logic             clock,
   input logic             reset,
   oudmm_stream_if.sink    req_ch,
   oudmm_stream_if.source  rsp_ch
);

   localparam int STEPS  = oudmm_pkg::HALF / LANES;
   localparam int STEP_W = $clog2(STEPS);
   localparam int LANE_W = $clog2(LANES);

   oudmm_pkg::state_type  state_ff;
   oudmm_pkg::state_type  state_in;
   logic [STEP_W-1:0]     step_ff;
   logic [STEP_W-1:0]     step_in;
   logic                  step_last;
   oudmm_pkg::points_type pts_ff;
   oudmm_pkg::points_type pts_in;
   oudmm_pkg::req_type    req_data;
   oudmm_pkg::ctl_type    issue;
   oudmm_pkg::ctl_type    ctl_d1_ff;
   oudmm_pkg::ctl_type    ctl_d2_ff;
   oudmm_pkg::point_type  lane_unit [LANES];
   oudmm_pkg::mask_type   lane_mask [LANES];
   logic                  merge_done;
   oudmm_pkg::mask_type   merge_result;
   logic                  req_take;
   logic                  rsp_load;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   oudmm_pkg::rsp_type    rsp_data_ff;
   oudmm_pkg::rsp_type    rsp_data_in;

   assign req_data  = req_ch.data;
   assign step_last = (step_ff == STEP_W'(STEPS - 1));

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         oudmm_pkg::ST_IDLE: begin
            if (req_ch.valid) begin
               state_in = oudmm_pkg::ST_SWEEP;
            end
         end
         oudmm_pkg::ST_SWEEP: begin
            if (step_last) begin
               state_in = oudmm_pkg::ST_DRAIN;
            end
         end
         oudmm_pkg::ST_DRAIN: begin
            if (merge_done) begin
               state_in = oudmm_pkg::ST_HOLD;
            end
         end
         oudmm_pkg::ST_HOLD: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               state_in = oudmm_pkg::ST_IDLE;
            end
         end
         default: state_in = oudmm_pkg::ST_IDLE;
      endcase
   end

   // Outputs of the state machine.
   always_comb begin
      req_take = 1'b0;
      rsp_load = 1'b0;
      issue    = '0;
      unique case (state_ff)
         oudmm_pkg::ST_IDLE: begin
            req_take = 1'b1;
         end
         oudmm_pkg::ST_SWEEP: begin
            issue.valid = 1'b1;
            issue.first = (step_ff == '0);
            issue.last  = step_last;
         end
         oudmm_pkg::ST_DRAIN: begin
         end
         oudmm_pkg::ST_HOLD: begin
            rsp_load = !rsp_valid_ff || rsp_ch.ready;
         end
         default: begin
         end
      endcase
   end

   assign req_ch.ready = req_take;

   // Advance the step counter through the sweep; clear it otherwise.
   always_comb begin
      step_in = '0;
      if (issue.valid && !step_last) begin
         step_in = step_ff + STEP_W'(1);
      end
   end

   // Capture the support on acceptance and hold it for the whole sweep.
   always_comb begin
      pts_in = pts_ff;
      if (req_take && req_ch.valid) begin
         pts_in[0] = req_data.point_0;
         pts_in[1] = req_data.point_1;
         pts_in[2] = req_data.point_2;
         pts_in[3] = req_data.point_3;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= oudmm_pkg::ST_IDLE;
         step_ff   <= '0;
         ctl_d1_ff <= '0;
         ctl_d2_ff <= '0;
      end else begin
         state_ff  <= state_in;
         step_ff   <= step_in;
         ctl_d1_ff <= issue;
         ctl_d2_ff <= ctl_d1_ff;
      end
   end

   always_ff @(posedge clock) begin
      pts_ff <= pts_in;
   end

   // Lane l at step s covers odd unit 2*(s*LANES + l) + 1.
   for (genvar l = 0; l < LANES; l++) begin : g_lane
      assign lane_unit[l] = {step_ff, LANE_W'(l), 1'b1};

      oudmm_lane u_lane (
         .clock (clock),
         .pts   (pts_ff),
         .unit  (lane_unit[l]),
         .mask  (lane_mask[l])
      );
   end

   // The lane pipeline is two stages deep; the control beat is delayed to match.
   oudmm_merge #(
      .LANES (LANES)
   ) u_merge (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl_d2_ff),
      .lane_mask (lane_mask),
      .done      (merge_done),
      .result    (merge_result)
   );

   // Response register: load when free or being drained, drop once taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_load) begin
         rsp_valid_in           = 1'b1;
         rsp_data_in.min_mask   = merge_result;
         rsp_data_in.degenerate = (merge_result == '0);
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.data  = rsp_data_ff;

   // The last merged beat only ever lands after the sweep has finished.
   a_done_in_drain : assert property (@(posedge clock) disable iff (reset)
      merge_done |-> state_ff == oudmm_pkg::ST_DRAIN)
      else $error("merge finished outside the drain phase");

   // A fresh response only comes out of the hand-off state.
   a_rsp_from_hold : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == oudmm_pkg::ST_HOLD)
      else $error("response raised without a hand-off");

   // Degenerate flag agrees with the mask it accompanies.
   a_degenerate_flag : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_data_ff.degenerate == (rsp_data_ff.min_mask == '0))
      else $error("degenerate flag disagrees with min_mask");

   // No new request while a sweep is issuing or the lane stages still hold its beats.
   a_no_take_busy : assert property (@(posedge clock) disable iff (reset)
      issue.valid || ctl_d1_ff.valid || ctl_d2_ff.valid |-> !req_take)
      else $error("request taken while lanes busy");

endmodule

/* dv/odd_unit_distance_mask_min_tb.sv */
`timescale 1ns / 1ps
// Self-checking bench for odd_unit_distance_mask_min: random idling on both streams,
// with each response checked against a behavioural minimum-mask calculation.
// Depends on rtl/oudmm_pkg.sv, rtl/oudmm_stream_if.sv and the block's RTL.
module odd_unit_distance_mask_min_tb;

   localparam int RANDOM_SUPPORTS = 950;
   localparam int DRAIN_CYCLES    = 64;

   logic clock = 1'b0;
   logic reset = 1'b1;

   oudmm_stream_if #(.payload_type(oudmm_pkg::req_type)) req_ch ();
   oudmm_stream_if #(.payload_type(oudmm_pkg::rsp_type)) rsp_ch ();

   odd_unit_distance_mask_min dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch.sink),
      .rsp_ch (rsp_ch.source)
   );

   always #2 clock = ~clock;

   oudmm_pkg::req_type support_queue [$];   // supports still to be offered
   oudmm_pkg::rsp_type min_mask_due [$];    // predicted responses, oldest first
   int      supports_total  = 0;
   int      supports_taken  = 0;
   int      mismatch_count  = 0;
   logic    req_taken       = 1'b0;
   int      req_gap         = 0;
   int      rsp_stall       = 0;
   bit      req_calm        = 1'b0;
   bit      rsp_calm        = 1'b0;

   // Sweep all odd multipliers, build each one's distance mask and keep the smallest.
   function automatic oudmm_pkg::rsp_type predict_min_mask(input oudmm_pkg::req_type support);
      int unsigned        pts [oudmm_pkg::POINTS];
      int unsigned        img [oudmm_pkg::POINTS];
      int unsigned        d;
      int unsigned        fold_dist;
      logic [63:0]        best;
      logic [63:0]        m;
      bit                 bad;
      oudmm_pkg::rsp_type r;
      pts[0] = support.point_0 % oudmm_pkg::ORDER;
      pts[1] = support.point_1 % oudmm_pkg::ORDER;
      pts[2] = support.point_2 % oudmm_pkg::ORDER;
      pts[3] = support.point_3 % oudmm_pkg::ORDER;
      best = '1;
      for (int unsigned u = 1; u < oudmm_pkg::ORDER; u += 2) begin
         m   = '0;
         bad = 1'b0;
         for (int i = 0; i < oudmm_pkg::POINTS; i++)
            img[i] = (pts[i] * u) % oudmm_pkg::ORDER;
         for (int i = 0; i < oudmm_pkg::POINTS; i++) begin
            for (int j = i + 1; j < oudmm_pkg::POINTS; j++) begin
               d         = (img[j] + oudmm_pkg::ORDER - img[i]) % oudmm_pkg::ORDER;
               fold_dist = (d < oudmm_pkg::ORDER - d) ? d : oudmm_pkg::ORDER - d;
               // Zero, half-order or repeated distance kills this multiplier.
               if (fold_dist == 0 || fold_dist * 2 == oudmm_pkg::ORDER) bad = 1'b1;
               else if (m[fold_dist-1]) bad = 1'b1;
               else m[fold_dist-1] = 1'b1;
            end
         end
         if (bad) m = '0;
         if (m < best) best = m;
      end
      if (best == '1) best = '0;
      r.min_mask   = best[oudmm_pkg::MASK_W-1:0];
      r.degenerate = (best[oudmm_pkg::MASK_W-1:0] == '0);
      return r;
   endfunction

   function automatic oudmm_pkg::req_type make_support(input int a, input int b, input int c,
                                                       input int d);
      oudmm_pkg::req_type s;
      s.point_0 = a[oudmm_pkg::POINT_W-1:0];
      s.point_1 = b[oudmm_pkg::POINT_W-1:0];
      s.point_2 = c[oudmm_pkg::POINT_W-1:0];
      s.point_3 = d[oudmm_pkg::POINT_W-1:0];
      return s;
   endfunction

   // Mostly short gaps, now and then a long one; none at all in a calm stretch.
   function automatic int draw_idle(input bit calm);
      int r;
      r = $urandom_range(0, 99);
      if (calm)   return 0;
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // Fill the request queue: directed corners first, then the random body.
   initial begin
      int                 p [oudmm_pkg::POINTS];
      int                 kind;
      int                 a;
      int                 b;
      oudmm_pkg::req_type s;
      // All-equal points, both ends of the field range.
      support_queue.push_back(make_support(0, 0, 0, 0));
      support_queue.push_back(make_support(127, 127, 127, 127));
      // Two coincident pairs: repeated distance.
      support_queue.push_back(make_support(0, 127, 0, 127));
      // Same set of points in three orders; the result must not change.
      support_queue.push_back(make_support(0, 1, 3, 7));
      support_queue.push_back(make_support(7, 3, 1, 0));
      support_queue.push_back(make_support(3, 0, 7, 1));
      // Distances one to six, each once.
      support_queue.push_back(make_support(0, 1, 4, 6));
      // Half-order distance.
      support_queue.push_back(make_support(0, 64, 1, 3));
      // Points straddling the wrap at zero.
      support_queue.push_back(make_support(127, 0, 2, 5));
      support_queue.push_back(make_support(127, 126, 124, 120));
      support_queue.push_back(make_support(0, 1, 2, 3));
      support_queue.push_back(make_support(0, 32, 64, 96));
      support_queue.push_back(make_support(1, 2, 4, 8));
      support_queue.push_back(make_support(0, 5, 0, 9));
      // Alternating bit patterns (85 and 42), mixed with other values.
      support_queue.push_back(make_support(85, 42, 21, 106));
      support_queue.push_back(make_support(42, 85, 106, 21));

      for (int n = 0; n < RANDOM_SUPPORTS; n++) begin
         for (int i = 0; i < oudmm_pkg::POINTS; i++)
            p[i] = $urandom_range(0, oudmm_pkg::ORDER - 1);
         kind = $urandom_range(0, 99);
         a    = $urandom_range(0, oudmm_pkg::POINTS - 1);
         b    = (a + $urandom_range(1, oudmm_pkg::POINTS - 1)) % oudmm_pkg::POINTS;
         if (kind < 70) begin
            // fully random support
         end else if (kind < 82) begin
            p[b] = p[a];                                            // coincident points
         end else if (kind < 92) begin
            p[b] = (p[a] + oudmm_pkg::ORDER / 2) % oudmm_pkg::ORDER; // half-order pair
         end else begin
            // tight cluster, often across the wrap
            for (int i = 1; i < oudmm_pkg::POINTS; i++)
               p[i] = (p[0] + $urandom_range(1, 9)) % oudmm_pkg::ORDER;
         end
         s = make_support(p[0], p[1], p[2], p[3]);
         support_queue.push_back(s);
      end
      supports_total = support_queue.size();
   end

   // Request driver: change on the falling edge, hold until accepted.
   always @(negedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         req_ch.data  <= '0;
      end else if (req_ch.valid && !req_taken) begin
         // hold the current request
      end else if (req_gap > 0) begin
         req_ch.valid <= 1'b0;
         req_gap--;
      end else if (support_queue.size() > 0) begin
         req_ch.data  <= support_queue.pop_front();
         req_ch.valid <= 1'b1;
         if ($urandom_range(0, 49) == 0) req_calm = !req_calm;
         req_gap = draw_idle(req_calm);
      end else begin
         req_ch.valid <= 1'b0;
      end
   end

   // Response back-pressure: random stalls, with calm stretches of constant ready.
   always @(negedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (rsp_stall > 0) begin
         rsp_ch.ready <= 1'b0;
         rsp_stall--;
      end else begin
         rsp_ch.ready <= 1'b1;
         if ($urandom_range(0, 199) == 0) rsp_calm = !rsp_calm;
         if ($urandom_range(0, 3) == 0) rsp_stall = draw_idle(rsp_calm);
      end
   end

   // Monitor: predict on each accepted request, check each accepted response.
   always @(posedge clock) begin
      oudmm_pkg::rsp_type got;
      oudmm_pkg::rsp_type want;
      req_taken <= !reset && req_ch.valid && req_ch.ready;
      if (!reset && req_ch.valid && req_ch.ready) begin
         min_mask_due.push_back(predict_min_mask(req_ch.data));
         supports_taken++;
      end
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got = rsp_ch.data;
         if (min_mask_due.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("%0t: response with none outstanding: min_mask %h degenerate %b",
                        $realtime, got.min_mask, got.degenerate);
         end else begin
            want = min_mask_due.pop_front();
            if (got.min_mask !== want.min_mask || got.degenerate !== want.degenerate) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("%0t: min_mask exp %h got %h, degenerate exp %b got %b",
                           $realtime, want.min_mask, got.min_mask,
                           want.degenerate, got.degenerate);
            end
         end
      end
   end

   // Sequence the run: reset, let every request through, drain, then report.
   initial begin
      req_ch.valid = 1'b0;
      req_ch.data  = '0;
      rsp_ch.ready = 1'b0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      wait (supports_total > 0);
      while (supports_taken < supports_total) @(posedge clock);
      while (min_mask_due.size() != 0) @(posedge clock);
      // Allow any stray response to show up before the verdict.
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (min_mask_due.size() != 0) mismatch_count++;
      if (mismatch_count == 0) begin
         $display("PASS odd_unit_distance_mask_min");
      end else begin
         $display("FAIL odd_unit_distance_mask_min");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run.
   initial begin
      #4ms;
      $display("FAIL odd_unit_distance_mask_min");
      $finish;
   end

endmodule
